// ===== design/slw_pkg.sv =====
// shared types, codes and font table for the segment lcd serial writer
package slw_pkg;

    localparam int FRAME_W   = 17;
    localparam int CNT_W     = 5;
    localparam int PHASE_W   = 12;

    localparam logic [11:0] PHASE_RESET = 12'd20;

    localparam logic [1:0] ACT_RAW   = 2'd0;
    localparam logic [1:0] ACT_DIGIT = 2'd1;
    localparam logic [1:0] ACT_DOT   = 2'd2;
    localparam logic [1:0] ACT_CMD   = 2'd3;

    localparam logic [2:0] WR_MODE   = 3'b101;
    localparam logic [3:0] CMD_MODE  = 4'b1000;
    localparam logic [7:0] DOT_MASK  = 8'h08;

    localparam logic [CNT_W-1:0] WR_BITS  = 5'd17;
    localparam logic [CNT_W-1:0] CMD_BITS = 5'd12;

    typedef struct packed {
        logic load;        // capture a new frame from the input beat
        logic phase_load;  // restart the strobe phase counter
        logic emit;        // push the current bit and shift
    } slw_cmd_t;

    typedef struct packed {
        logic phase_done;
        logic bit_last;
        logic out_space;
    } slw_status_t;

    function automatic logic [7:0] seg_font(input logic [7:0] code);
        logic [7:0] pat;
        unique case (code)
            8'd0:    pat = 8'hf5;
            8'd1:    pat = 8'h05;
            8'd2:    pat = 8'hd3;
            8'd3:    pat = 8'h97;
            8'd4:    pat = 8'h27;
            8'd5:    pat = 8'hb6;
            8'd6:    pat = 8'hf6;
            8'd7:    pat = 8'h15;
            8'd8:    pat = 8'hf7;
            8'd9:    pat = 8'hb7;
            8'd10:   pat = 8'h02;
            8'd11:   pat = 8'h80;
            8'd12:   pat = 8'h67;
            8'd13:   pat = 8'hf2;
            8'd14:   pat = 8'he0;
            8'd15:   pat = 8'h73;
            default: pat = 8'h00;  // code sixteen and anything above is blank
        endcase
        return pat;
    endfunction

endpackage

// ===== design/slw_dp.sv =====
// datapath: frame shifter, bit and phase counters, output register
module slw_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [11:0]               cfg_wr_data,
    input  logic [1:0]                action,
    input  logic [4:0]                address,
    input  logic [7:0]                value,
    input  slw_pkg::slw_cmd_t         cmd,
    output slw_pkg::slw_status_t      status,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      data_bit,
    output logic                      last
);
    import slw_pkg::*;

    logic [PHASE_W-1:0] phase_cycles_reg;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [CNT_W-1:0]   bits_left_reg, bits_left_next;
    logic [PHASE_W-1:0] phase_cnt_reg, phase_cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_data_reg, out_last_reg;
    logic [7:0]         byte_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_cycles_reg <= PHASE_RESET;
        end
        else if (cfg_wr_en)
        begin
            // a zero write is stored as one
            phase_cycles_reg <= (cfg_wr_data == '0) ? PHASE_W'(1) : cfg_wr_data;
        end
    end

    always_comb
    begin
        unique case (action)
            ACT_RAW:   byte_sel = value;
            ACT_DIGIT: byte_sel = seg_font(value);
            ACT_DOT:   byte_sel = seg_font(value) | DOT_MASK;
            default:   byte_sel = value;
        endcase
    end

    always_comb
    begin
        frame_next     = frame_reg;
        bits_left_next = bits_left_reg;
        if (cmd.load)
        begin
            // frames are left aligned so the outgoing bit is always the msb
            if (action == ACT_CMD)
            begin
                frame_next     = {CMD_MODE, value, 5'b0};
                bits_left_next = CMD_BITS;
            end
            else
            begin
                frame_next     = {WR_MODE, address, 1'b0, byte_sel};
                bits_left_next = WR_BITS;
            end
        end
        else if (cmd.emit)
        begin
            frame_next     = {frame_reg[FRAME_W-2:0], 1'b0};
            bits_left_next = bits_left_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        phase_cnt_next = phase_cnt_reg;
        if (cmd.phase_load)
        begin
            phase_cnt_next = phase_cycles_reg;
        end
        else if (phase_cnt_reg > PHASE_W'(1))
        begin
            phase_cnt_next = phase_cnt_reg - PHASE_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg     <= '0;
            bits_left_reg <= '0;
            phase_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            frame_reg     <= frame_next;
            bits_left_reg <= bits_left_next;
            phase_cnt_reg <= phase_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg <= frame_reg[FRAME_W-1];
            out_last_reg <= (bits_left_reg == CNT_W'(1));
        end
    end

    assign status.phase_done = (phase_cnt_reg == PHASE_W'(1));
    assign status.bit_last   = (bits_left_reg == CNT_W'(1));
    assign status.out_space  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign data_bit  = out_data_reg;
    assign last      = out_last_reg;

`ifndef SYNTH
    a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
        bits_left_reg <= WR_BITS)
        else $error("bit counter out of range");

    a_emit_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> bits_left_reg != '0)
        else $error("bit pushed from an empty frame");
`endif

endmodule

// ===== design/slw_ctrl.sv =====
// controller: sequences the three strobe phases of every bit
module slw_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  slw_pkg::slw_status_t      status,
    output slw_pkg::slw_cmd_t         cmd
);
    import slw_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LOW    = 2'd1;
    localparam logic [1:0] S_LAUNCH = 2'd2;
    localparam logic [1:0] S_HIGH   = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd.load       = 1'b0;
        cmd.phase_load = 1'b0;
        cmd.emit       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load       = 1'b1;
                    cmd.phase_load = 1'b1;
                    state_next     = S_LOW;
                end
            end
            S_LOW:
            begin
                if (status.phase_done)
                begin
                    cmd.phase_load = 1'b1;
                    state_next     = S_LAUNCH;
                end
            end
            S_LAUNCH:
            begin
                if (status.phase_done)
                begin
                    cmd.phase_load = 1'b1;
                    state_next     = S_HIGH;
                end
            end
            S_HIGH:
            begin
                // rising strobe edge: hold here while the output beat is stuck
                if (status.phase_done && status.out_space)
                begin
                    cmd.emit = 1'b1;
                    if (status.bit_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.phase_load = 1'b1;
                        state_next     = S_LOW;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_LOW)
        else $error("accepted beat did not start a frame");

    a_emit_space: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_space)
        else $error("bit pushed into a full output register");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && status.bit_last |=> state_reg == S_IDLE)
        else $error("frame did not end after its last bit");
`endif

endmodule

// ===== design/segment_lcd_serial_writer.sv =====
// top level of the segment lcd serial writer
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------
//  request  | in_valid / in_ready   | action, address, value
//  bit out  | out_valid / out_ready | data_bit, last
//  config   | cfg_wr_en             | cfg_wr_data (phase_cycles)
//
// one request gives 17 bits (data write) or 12 bits (command), one beat each
// each bit takes three strobe phases whose length is phase_cycles (0 taken as 1)
// the phase counter in the datapath times every strobe phase
// a stalled bit beat holds the sequencer at the end of the strobe high phase
// reset restores phase_cycles to 20 and leaves the block idle with no beat pending
module segment_lcd_serial_writer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [11:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [4:0]  address,
    input  logic [7:0]  value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        data_bit,
    output logic        last
);
    import slw_pkg::*;

    slw_cmd_t    cmd;
    slw_status_t status;

    slw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    slw_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .action      (action),
        .address     (address),
        .value       (value),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .data_bit    (data_bit),
        .last        (last)
    );

endmodule

// ===== test/tb.sv =====
// testbench for the segment lcd serial writer: queued requests, bit-by-bit frame checking
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import slw_pkg::*;

    localparam int WATCHDOG_LIMIT = 100000;
    localparam int HOLD_CYCLES    = 400;
    localparam int MAX_SHOWN      = 10;

    // seven-segment patterns for digit codes 0..16
    localparam logic [7:0] GLYPHS [0:16] = '{
        8'hf5, 8'h05, 8'hd3, 8'h97, 8'h27, 8'hb6, 8'hf6, 8'h15, 8'hf7,
        8'hb7, 8'h02, 8'h80, 8'h67, 8'hf2, 8'he0, 8'h73, 8'h00
    };

    typedef struct {
        logic [1:0] action;
        logic [4:0] address;
        logic [7:0] value;
    } lcd_req_t;

    typedef struct {
        logic data_bit;
        logic last;
    } lcd_bit_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [11:0] cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  action = '0;
    logic [4:0]  address = '0;
    logic [7:0]  value = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        data_bit;
    logic        last;

    lcd_req_t pend_q[$];
    lcd_bit_t frame_bits_q[$];

    logic        req_fired = 1'b0;
    logic        beat_fired = 1'b0;
    logic        idle_on = 1'b1;
    int unsigned req_gap_left = 0;
    int unsigned rdy_wait_left = 0;
    int unsigned hold_left = 0;
    int unsigned hold_reqs = 0;
    int unsigned hold_done = 0;
    int unsigned quiet_cycles = 0;
    int unsigned err_cnt = 0;
    int          eff_phase = 20;

    segment_lcd_serial_writer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .address    (address),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data_bit   (data_bit),
        .last       (last)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] glyph_of(input logic [7:0] code);
        if (code < 8'd17)
            return GLYPHS[code[4:0]];
        return 8'h00;
    endfunction

    // build the serial frame for one request and queue its bits msb first
    function automatic void queue_frame_bits(input lcd_req_t r);
        logic [16:0] frame;
        logic [7:0]  seg_byte;
        int          nbits;
        lcd_bit_t    b;
        if (r.action == ACT_CMD)
        begin
            frame = {5'b0, CMD_MODE, r.value};
            nbits = 12;
        end
        else
        begin
            if (r.action == ACT_RAW)
                seg_byte = r.value;
            else if (r.action == ACT_DIGIT)
                seg_byte = glyph_of(r.value);
            else
                seg_byte = glyph_of(r.value) | DOT_MASK;
            frame = {WR_MODE, r.address, 1'b0, seg_byte};
            nbits = 17;
        end
        for (int i = nbits - 1; i >= 0; i--)
        begin
            b.data_bit = frame[i];
            b.last     = (i == 0);
            frame_bits_q.push_back(b);
        end
    endfunction

    task automatic offer_next();
        lcd_req_t nxt;
        nxt = pend_q.pop_front();
        action   <= nxt.action;
        address  <= nxt.address;
        value    <= nxt.value;
        in_valid <= 1'b1;
    endtask

    // request driver
    always @(negedge clk)
    begin
        int unsigned g;
        if (in_valid && !req_fired)
        begin
            // beat still waiting for ready
        end
        else if (in_valid)
        begin
            g = idle_on ? $urandom_range(0, 10) : 0;
            if (g == 0 && pend_q.size() > 0)
            begin
                offer_next();
            end
            else
            begin
                in_valid     <= 1'b0;
                req_gap_left <= g;
            end
        end
        else if (req_gap_left > 0)
        begin
            req_gap_left <= req_gap_left - 1;
        end
        else if (pend_q.size() > 0)
        begin
            offer_next();
        end
    end

    // bit receiver
    always @(negedge clk)
    begin
        int unsigned w;
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_reqs != hold_done)
        begin
            hold_done <= hold_done + 1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (out_ready && beat_fired)
        begin
            w = idle_on ? $urandom_range(0, 10) : 0;
            if (w != 0)
            begin
                out_ready     <= 1'b0;
                rdy_wait_left <= w;
            end
        end
        else if (!out_ready)
        begin
            if (rdy_wait_left > 0)
                rdy_wait_left <= rdy_wait_left - 1;
            else
                out_ready <= 1'b1;
        end
    end

    // predictor and checker
    always @(posedge clk)
    begin
        lcd_req_t r;
        lcd_bit_t exp_b;
        req_fired  <= rst_n && in_valid && in_ready;
        beat_fired <= rst_n && out_valid && out_ready;
        if (rst_n && in_valid && in_ready)
        begin
            r.action  = action;
            r.address = address;
            r.value   = value;
            queue_frame_bits(r);
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (frame_bits_q.size() == 0)
            begin
                if (err_cnt < MAX_SHOWN)
                    $display("bit beat with nothing pending: data_bit=%0b last=%0b",
                             data_bit, last);
                err_cnt++;
            end
            else
            begin
                exp_b = frame_bits_q.pop_front();
                if (data_bit !== exp_b.data_bit || last !== exp_b.last)
                begin
                    if (err_cnt < MAX_SHOWN)
                        $display({"bit mismatch: expected data_bit=%0b last=%0b, ",
                                  "got data_bit=%0b last=%0b"},
                                 exp_b.data_bit, exp_b.last, data_bit, last);
                    err_cnt++;
                end
            end
        end
    end

    // stall watchdog
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic add_req(input logic [1:0] a, input logic [4:0] ad, input logic [7:0] v);
        lcd_req_t r;
        r.action  = a;
        r.address = ad;
        r.value   = v;
        pend_q.push_back(r);
    endtask

    task automatic add_random(input int n);
        logic [1:0] a;
        logic [7:0] v;
        @(posedge clk);
        for (int i = 0; i < n; i++)
        begin
            a = 2'($urandom_range(0, 3));
            // digit and dot requests mostly carry codes from 0 to 16
            if ((a == ACT_DIGIT || a == ACT_DOT) && $urandom_range(0, 9) < 8)
                v = 8'($urandom_range(0, 16));
            else
                v = 8'($urandom_range(0, 255));
            add_req(a, 5'($urandom_range(0, 31)), v);
        end
    endtask

    // wait until every request is sent and every bit is back, then let the strobe finish
    task automatic settle();
        @(negedge clk);
        while (pend_q.size() > 0 || in_valid || frame_bits_q.size() > 0)
            @(negedge clk);
        repeat (3 * eff_phase + 20) @(negedge clk);
    endtask

    task automatic set_phase(input logic [11:0] p);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= p;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        eff_phase = (p == 0) ? 1 : int'(p);
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // directed requests at the reset strobe timing
        @(posedge clk);
        add_req(ACT_RAW, 5'd0, 8'h00);
        add_req(ACT_RAW, 5'd31, 8'hff);
        add_req(ACT_RAW, 5'd21, 8'ha5);
        for (int c = 0; c <= 16; c++)
            add_req(ACT_DIGIT, c[4:0], c[7:0]);
        add_req(ACT_DIGIT, 5'd10, 8'd200);
        add_req(ACT_DOT, 5'd3, 8'd5);
        add_req(ACT_DOT, 5'd17, 8'd17);
        add_req(ACT_DOT, 5'd31, 8'hff);
        add_req(ACT_CMD, 5'd31, 8'h00);
        add_req(ACT_CMD, 5'd0, 8'hff);
        settle();

        // fastest strobe with a long receiver stall so the block backs up
        set_phase(12'd1);
        add_random(120);
        hold_reqs <= hold_reqs + 1;
        settle();

        // zero phase acts as one; no idling on either side
        set_phase(12'd0);
        idle_on <= 1'b0;
        add_random(60);
        settle();

        set_phase(12'd3);
        idle_on <= 1'b1;
        add_random(55);
        settle();

        // slowest strobe, one request only
        set_phase(12'd4095);
        @(posedge clk);
        add_req(ACT_RAW, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
        settle();

        set_phase(12'd2);
        add_random(70);
        settle();

        if (err_cnt == 0 && frame_bits_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
